### hdl/step_resampler_pcm_top_assert.svh
// assertion macros for the step resampler checker
`ifndef STEP_RESAMPLER_PCM_TOP_ASSERT_SVH
`define STEP_RESAMPLER_PCM_TOP_ASSERT_SVH

// same-cycle implication, quiet during reset
`define SRPCM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srpcm check failed");

// next-cycle implication, quiet during reset
`define SRPCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srpcm check failed");

`endif

### hdl/srpcm_pkg.sv
// package: constants, types and sample conversion for the step resampler
package srpcm_pkg;

    localparam int COUNT_BITS = 24;
    localparam int PHASE_BITS = 32;
    localparam int FRAC_BITS  = 8;
    localparam int PINT_BITS  = PHASE_BITS - FRAC_BITS;
    localparam int CMP_W      = (COUNT_BITS > 24) ? COUNT_BITS : 24;
    localparam int RUN_MAX    = 64;
    localparam int RUN_W      = $clog2(RUN_MAX + 1);
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [11:0] MIN_STEP   = 12'd4;
    localparam logic [11:0] STEP_RESET = 12'd256;
    localparam logic [7:0]  BYTE_BIAS  = 8'd128;

    typedef enum logic [1:0] {
        REG_STEP     = 2'd0,
        REG_SRC16    = 2'd1,
        REG_OUT16    = 2'd2,
        REG_OUTCOUNT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [11:0] step_q8;
        logic        source_is_16bit;
        logic        output_is_16bit;
        logic [23:0] output_count;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic emit;
        logic last;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic hit;
        logic more;
        logic out_free;
    } status_t;

    function automatic logic signed [15:0] convert(input logic [15:0] raw,
                                                   input logic src16,
                                                   input logic out16);
        logic [15:0] s16;
        s16 = src16 ? raw : {raw[7:0] ^ BYTE_BIAS, 8'h00};
        if (out16)
            return signed'(s16);
        return signed'({{8{s16[15]}}, s16[15:8]});
    endfunction

endpackage

### hdl/srpcm_if.sv
// valid/ready word channels for source samples and converted samples
interface srpcm_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] src_sample;

    modport source (output valid, output src_sample, input ready);
    modport sink (input valid, input src_sample, output ready);
endinterface

interface srpcm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_sample;
    logic               last_of_run;
    logic               final_sample;

    modport source (output valid, output out_sample, output last_of_run,
                    output final_sample, input ready);
    modport sink (input valid, input out_sample, input last_of_run,
                  input final_sample, output ready);
endinterface

### hdl/srpcm_regs.sv
// apb register file for step, formats and output count
module srpcm_regs
    import srpcm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_q8         <= STEP_RESET;
            cfg_reg.source_is_16bit <= 1'b0;
            cfg_reg.output_is_16bit <= 1'b1;
            cfg_reg.output_count    <= 24'd0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_STEP:     cfg_reg.step_q8         <= pwdata[11:0];
                REG_SRC16:    cfg_reg.source_is_16bit <= pwdata[0];
                REG_OUT16:    cfg_reg.output_is_16bit <= pwdata[0];
                REG_OUTCOUNT: cfg_reg.output_count    <= pwdata[23:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_STEP:     prdata = DATA_W'(cfg_reg.step_q8);
            REG_SRC16:    prdata = DATA_W'(cfg_reg.source_is_16bit);
            REG_OUT16:    prdata = DATA_W'(cfg_reg.output_is_16bit);
            REG_OUTCOUNT: prdata = DATA_W'(cfg_reg.output_count);
            default:      prdata = '0;
        endcase
    end

endmodule

### hdl/srpcm_dp.sv
// datapath: phase accumulator, counters, sample conversion and output register
module srpcm_dp
    import srpcm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  cmd_t               cmd,
    output status_t            st,
    input  logic [15:0]        src_sample,
    input  logic               out_ready,
    output logic               out_valid,
    output logic signed [15:0] out_sample,
    output logic               last_of_run,
    output logic               final_sample
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [COUNT_BITS-1:0] src_idx_reg;
    logic [COUNT_BITS-1:0] out_idx_reg, out_idx_next;
    logic [RUN_W-1:0]      run_cnt_reg;
    logic signed [15:0]    sample_reg;
    logic                  out_valid_reg;
    logic signed [15:0]    out_sample_reg;
    logic                  last_reg;
    logic                  final_reg;
    logic [11:0]           step_eff;
    logic                  final_flag;
    logic                  room_now;
    logic                  room_next;

    assign step_eff     = (cfg.step_q8 < MIN_STEP) ? MIN_STEP : cfg.step_q8;
    assign phase_next   = phase_reg + PHASE_BITS'(step_eff);
    assign out_idx_next = (out_idx_reg == CNT_MAX) ? out_idx_reg : out_idx_reg + 1'b1;
    assign final_flag   = CMP_W'(out_idx_next) >= CMP_W'(cfg.output_count);
    assign room_now     = run_cnt_reg < RUN_W'(RUN_MAX);
    assign room_next    = run_cnt_reg < RUN_W'(RUN_MAX - 1);

    assign st.done     = CMP_W'(out_idx_reg) >= CMP_W'(cfg.output_count);
    assign st.hit      = (phase_reg[PHASE_BITS-1:FRAC_BITS] == PINT_BITS'(src_idx_reg))
                         && room_now && !st.done;
    assign st.more     = (phase_next[PHASE_BITS-1:FRAC_BITS] == PINT_BITS'(src_idx_reg))
                         && room_next && !final_flag;
    assign st.out_free = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_sample   = out_sample_reg;
    assign last_of_run  = last_reg;
    assign final_sample = final_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            src_idx_reg   <= '0;
            out_idx_reg   <= '0;
            run_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                run_cnt_reg <= '0;
            if (cmd.emit)
            begin
                phase_reg     <= phase_next;
                out_idx_reg   <= out_idx_next;
                run_cnt_reg   <= run_cnt_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.advance)
                src_idx_reg <= src_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            sample_reg <= convert(src_sample, cfg.source_is_16bit, cfg.output_is_16bit);
        if (cmd.emit)
        begin
            out_sample_reg <= sample_reg;
            last_reg       <= cmd.last;
            final_reg      <= final_flag;
        end
    end

endmodule

### hdl/srpcm_ctrl.sv
// controller: accepts a source word and sequences its run of outputs
module srpcm_ctrl
    import srpcm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && !st.done)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (!st.hit)
                begin
                    // sample skipped over
                    cmd.advance = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = !st.more;
                    if (!st.more)
                    begin
                        cmd.advance = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

### hdl/step_resampler_pcm_top.sv
// Nearest-neighbour PCM rate converter with a 24.8 phase accumulator. Each
// source word is taken and then yields one output word per cycle, while the
// output is not stalled, for as long as the phase integer matches its index
// (at most 64); the output register lets the next source word be taken while
// the last output waits. Once output_count outputs are done, source words
// are taken and dropped.
module step_resampler_pcm_top
    import srpcm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    srpcm_in_if.sink          in_ch,
    srpcm_out_if.source       out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t st;

    srpcm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srpcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .st       (st),
        .cmd      (cmd)
    );

    srpcm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .st           (st),
        .src_sample   (in_ch.src_sample),
        .out_ready    (out_ch.ready),
        .out_valid    (out_ch.valid),
        .out_sample   (out_ch.out_sample),
        .last_of_run  (out_ch.last_of_run),
        .final_sample (out_ch.final_sample)
    );

endmodule

### hdl/srpcm_checker.sv
// port-level checker for the step resampler and its bind
`include "step_resampler_pcm_top_assert.svh"

module srpcm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_sample,
    input logic        last_of_run,
    input logic        final_sample
);

    `SRPCM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `SRPCM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_sample))
    `SRPCM_ASSERT_NOW(a_final_ends_run, out_valid && final_sample, last_of_run)

endmodule

bind step_resampler_pcm_top srpcm_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_sample   (out_ch.out_sample),
    .last_of_run  (out_ch.last_of_run),
    .final_sample (out_ch.final_sample)
);
